@@ hdl/nnts_pkg.sv @@
// Shared types, widths and codes for the nearest-neighbor texture scaler.
package nnts_pkg;

  // Default sizes, handed to the top-level parameters.
  localparam int STORE_DEPTH_DEF = 4096;
  localparam int MAX_SRC_DIM_DEF = 256;
  localparam int MAX_DST_DIM_DEF = 1024;

  // Field and register widths.
  localparam int INDEX_W   = 12;
  localparam int PIXEL_W   = 8;
  localparam int COORD_W   = 10;
  localparam int SRC_DIM_W = 9;
  localparam int DST_DIM_W = 11;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 11;

  // Scaled coordinate = coord * src_dim, divided by dst_dim.
  // The coordinate is below dst_dim, so the quotient is below src_dim.
  localparam int NUM_W  = COORD_W + SRC_DIM_W;
  localparam int QUO_W  = SRC_DIM_W;
  localparam int ADDR_W = QUO_W + SRC_DIM_W;

  // Item commands.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;

  typedef struct packed {
    logic                 cmd;
    logic [INDEX_W-1:0]   src_index;
    logic [PIXEL_W-1:0]   pixel_in;
    logic [COORD_W-1:0]   dst_x;
    logic [COORD_W-1:0]   dst_y;
  } in_word_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_out;
    logic               out_of_range;
  } out_word_t;

  typedef struct packed {
    logic [SRC_DIM_W-1:0] src_width;
    logic [SRC_DIM_W-1:0] src_height;
    logic [DST_DIM_W-1:0] dst_width;
    logic [DST_DIM_W-1:0] dst_height;
  } cfg_t;

  // Item data that rides along the arithmetic stages.
  typedef struct packed {
    logic               cmd;
    logic [INDEX_W-1:0] src_index;
    logic [PIXEL_W-1:0] pixel_in;
    logic               bad;
  } meta_t;

  typedef struct packed {
    meta_t            meta;
    logic [NUM_W-1:0] num_x;
    logic [NUM_W-1:0] num_y;
  } prod_t;

  typedef struct packed {
    meta_t            meta;
    logic [QUO_W-1:0] sx;
    logic [QUO_W-1:0] sy;
  } coord_t;

endpackage

@@ hdl/nnts_front.sv @@
// Input register, range checks and the two coordinate products.
module nnts_front #(
  parameter int MAX_SRC_DIM = nnts_pkg::MAX_SRC_DIM_DEF,
  parameter int MAX_DST_DIM = nnts_pkg::MAX_DST_DIM_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  nnts_pkg::cfg_t    cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  nnts_pkg::in_word_t in_word,
  output logic              out_valid,
  input  logic              out_ready,
  output nnts_pkg::prod_t   out_prod
);
  import nnts_pkg::*;

  logic     v0, v1;
  in_word_t w0;
  prod_t    p1, p1_next;
  logic     s1_ready;
  logic     dims_ok;

  assign s1_ready = !v1 || out_ready;
  assign in_ready = !v0 || s1_ready;

  assign dims_ok = (cfg.src_width  != '0) && (32'(cfg.src_width)  <= MAX_SRC_DIM) &&
                   (cfg.src_height != '0) && (32'(cfg.src_height) <= MAX_SRC_DIM) &&
                   (cfg.dst_width  != '0) && (32'(cfg.dst_width)  <= MAX_DST_DIM) &&
                   (cfg.dst_height != '0) && (32'(cfg.dst_height) <= MAX_DST_DIM);

  always_comb begin
    p1_next.meta.cmd       = w0.cmd;
    p1_next.meta.src_index = w0.src_index;
    p1_next.meta.pixel_in  = w0.pixel_in;
    p1_next.meta.bad       = !dims_ok ||
                             ({1'b0, w0.dst_x} >= cfg.dst_width) ||
                             ({1'b0, w0.dst_y} >= cfg.dst_height);
    p1_next.num_x = NUM_W'(w0.dst_x) * NUM_W'(cfg.src_width);
    p1_next.num_y = NUM_W'(w0.dst_y) * NUM_W'(cfg.src_height);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      if (in_ready) begin
        v0 <= in_valid;
      end
      if (s1_ready) begin
        v1 <= v0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      w0 <= in_word;
    end
    if (s1_ready) begin
      p1 <= p1_next;
    end
  end

  assign out_valid = v1;
  assign out_prod  = p1;

endmodule

@@ hdl/nnts_divider.sv @@
// Pipelined restoring divider, one quotient bit per stage for both axes.
module nnts_divider (
  input  logic             clk,
  input  logic             rst,
  input  nnts_pkg::cfg_t   cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  nnts_pkg::prod_t  in_prod,
  output logic             out_valid,
  input  logic             out_ready,
  output nnts_pkg::coord_t out_coord
);
  import nnts_pkg::*;

  typedef struct packed {
    meta_t                meta;
    logic [DST_DIM_W-1:0] rem_x;
    logic [DST_DIM_W-1:0] rem_y;
    logic [QUO_W-1:0]     num_x;
    logic [QUO_W-1:0]     num_y;
    logic [QUO_W-1:0]     q_x;
    logic [QUO_W-1:0]     q_y;
  } div_stage_t;

  // One restoring step: bring down the next numerator bit, subtract if it fits.
  function automatic div_stage_t div_step(div_stage_t s, logic [DST_DIM_W-1:0] dw,
                                          logic [DST_DIM_W-1:0] dh);
    div_stage_t         r;
    logic [DST_DIM_W:0] tx, ty;
    logic               gx, gy;
    r  = s;
    tx = {s.rem_x, s.num_x[QUO_W-1]};
    ty = {s.rem_y, s.num_y[QUO_W-1]};
    gx = tx >= {1'b0, dw};
    gy = ty >= {1'b0, dh};
    r.rem_x = gx ? DST_DIM_W'(tx - {1'b0, dw}) : tx[DST_DIM_W-1:0];
    r.rem_y = gy ? DST_DIM_W'(ty - {1'b0, dh}) : ty[DST_DIM_W-1:0];
    r.num_x = s.num_x << 1;
    r.num_y = s.num_y << 1;
    r.q_x   = {s.q_x[QUO_W-2:0], gx};
    r.q_y   = {s.q_y[QUO_W-2:0], gy};
    return r;
  endfunction

  div_stage_t       st      [QUO_W];
  div_stage_t       st_next [QUO_W];
  div_stage_t       init_st;
  logic [QUO_W-1:0] v;
  logic             rdy [QUO_W+1];

  always_comb begin
    init_st.meta  = in_prod.meta;
    init_st.rem_x = DST_DIM_W'(in_prod.num_x[NUM_W-1:QUO_W]);
    init_st.rem_y = DST_DIM_W'(in_prod.num_y[NUM_W-1:QUO_W]);
    init_st.num_x = in_prod.num_x[QUO_W-1:0];
    init_st.num_y = in_prod.num_y[QUO_W-1:0];
    init_st.q_x   = '0;
    init_st.q_y   = '0;
  end

  always_comb begin
    st_next[0] = div_step(init_st, cfg.dst_width, cfg.dst_height);
    for (int k = 1; k < QUO_W; k++) begin
      st_next[k] = div_step(st[k-1], cfg.dst_width, cfg.dst_height);
    end
  end

  // A stage loads when it is empty or its content moves on.
  always_comb begin
    rdy[QUO_W] = out_ready;
    for (int k = QUO_W - 1; k >= 0; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < QUO_W; k++) begin
        if (rdy[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QUO_W; k++) begin
      if (rdy[k]) begin
        st[k] <= st_next[k];
      end
    end
  end

  assign in_ready       = rdy[0];
  assign out_valid      = v[QUO_W-1];
  assign out_coord.meta = st[QUO_W-1].meta;
  assign out_coord.sx   = st[QUO_W-1].q_x;
  assign out_coord.sy   = st[QUO_W-1].q_y;

endmodule

@@ hdl/nnts_fetch.sv @@
// Store address, texture store and output register.
module nnts_fetch #(
  parameter int STORE_DEPTH = nnts_pkg::STORE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [nnts_pkg::SRC_DIM_W-1:0] src_width,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  nnts_pkg::coord_t              in_coord,
  output logic                          out_valid,
  input  logic                          out_ready,
  output nnts_pkg::out_word_t           out_word
);
  import nnts_pkg::*;

  localparam int MEM_AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  logic [PIXEL_W-1:0] mem [STORE_DEPTH];

  logic              v1, v2;
  logic              cmd1;
  logic [MEM_AW-1:0] addr1;
  logic [PIXEL_W-1:0] pix1;
  logic              hit1;
  logic              f2_ready;
  logic              oor2;
  logic [PIXEL_W-1:0] rd2;

  logic [ADDR_W-1:0] rd_addr;
  logic              hit_next;
  logic [MEM_AW-1:0] addr_next;

  always_comb begin
    rd_addr = ADDR_W'(in_coord.sy) * ADDR_W'(src_width) + ADDR_W'(in_coord.sx);
    if (in_coord.meta.cmd == CMD_WRITE) begin
      hit_next  = 32'(in_coord.meta.src_index) < STORE_DEPTH;
      addr_next = MEM_AW'(in_coord.meta.src_index);
    end else begin
      hit_next  = !in_coord.meta.bad && (32'(rd_addr) < STORE_DEPTH);
      addr_next = MEM_AW'(rd_addr);
    end
  end

  assign f2_ready = !v2 || out_ready;
  assign in_ready = !v1 || f2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (in_ready) begin
        v1 <= in_valid;
      end
      // Writes end here and leave no result.
      if (f2_ready) begin
        v2 <= v1 && (cmd1 == CMD_READ);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      cmd1  <= in_coord.meta.cmd;
      addr1 <= addr_next;
      pix1  <= in_coord.meta.pixel_in;
      hit1  <= hit_next;
    end
    if (f2_ready) begin
      oor2 <= !hit1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1 && f2_ready) begin
      if (cmd1 == CMD_WRITE) begin
        if (hit1) begin
          mem[addr1] <= pix1;
        end
      end else begin
        rd2 <= mem[addr1];
      end
    end
  end

  assign out_valid             = v2;
  assign out_word.pixel_out    = oor2 ? '0 : rd2;
  assign out_word.out_of_range = oor2;

endmodule

@@ hdl/nearest_neighbor_texture_scaler.sv @@
// Top level of the nearest-neighbor texture scaler.
//
// The block holds a source texture of 8-bit pixels and answers read words with
// the nearest-neighbor sample of a scaled image. A write word (cmd 0) stores
// pixel_in at src_index and gives no result; a write beyond the store is
// dropped. A read word (cmd 1) maps (dst_x, dst_y) to source column
// floor(dst_x * src_width / dst_width) and row floor(dst_y * src_height /
// dst_height), both exact integer quotients, and returns the pixel at
// row * src_width + column. A coordinate outside the output size, a dimension
// register that is zero or above its maximum, or a source address beyond the
// store gives pixel_out 0 with out_of_range set. Reading a store entry that was
// never written returns an unspecified pixel. The block takes one word per
// clock while the output is not stalled. The input register is loaded at the
// accepting edge; the word then passes the coordinate multipliers, the
// pipelined divider that produces one quotient bit per stage for both axes,
// and the address multiply and the store read. Words keep their order, so a
// read issued after a write sees the written pixel. The dimension registers
// are written through the cfg port and may only change while no word is in
// flight.
module nearest_neighbor_texture_scaler #(
  parameter int STORE_DEPTH = nnts_pkg::STORE_DEPTH_DEF,
  parameter int MAX_SRC_DIM = nnts_pkg::MAX_SRC_DIM_DEF,
  parameter int MAX_DST_DIM = nnts_pkg::MAX_DST_DIM_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [nnts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nnts_pkg::CFG_DAT_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  nnts_pkg::in_word_t            in_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output nnts_pkg::out_word_t           out_word
);
  import nnts_pkg::*;

  cfg_t   cfg;
  logic   in_ready;
  logic   prod_valid, prod_ready;
  prod_t  prod;
  logic   coord_valid, coord_ready;
  coord_t coord;

  // Dimension registers; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.src_width  <= SRC_DIM_W'(1);
      cfg.src_height <= SRC_DIM_W'(1);
      cfg.dst_width  <= DST_DIM_W'(1);
      cfg.dst_height <= DST_DIM_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SRC_WIDTH:  cfg.src_width  <= cfg_data[SRC_DIM_W-1:0];
        REG_SRC_HEIGHT: cfg.src_height <= cfg_data[SRC_DIM_W-1:0];
        REG_DST_WIDTH:  cfg.dst_width  <= cfg_data[DST_DIM_W-1:0];
        REG_DST_HEIGHT: cfg.dst_height <= cfg_data[DST_DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Every stage keeps its own valid bit, so the input keeps flowing into
  // empty stages even while a finished result waits at the output.
  nnts_front #(
    .MAX_SRC_DIM (MAX_SRC_DIM),
    .MAX_DST_DIM (MAX_DST_DIM)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (prod_valid),
    .out_ready (prod_ready),
    .out_prod  (prod)
  );

  nnts_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (prod_valid),
    .in_ready  (prod_ready),
    .in_prod   (prod),
    .out_valid (coord_valid),
    .out_ready (coord_ready),
    .out_coord (coord)
  );

  nnts_fetch #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_fetch (
    .clk       (clk),
    .rst       (rst),
    .src_width (cfg.src_width),
    .in_valid  (coord_valid),
    .in_ready  (coord_ready),
    .in_coord  (coord),
    .out_valid (out_valid),
    .out_ready (!out_stall),
    .out_word  (out_word)
  );

  assign in_stall = !in_ready;

endmodule

@@ hdl/nnts_checker.sv @@
// Port-level checks for the texture scaler and their bind to the top level.
module nnts_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_stall,
  input nnts_pkg::out_word_t out_word
);
  import nnts_pkg::*;

  // A stalled result word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // A stalled result word does not change.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_word))
    else $error("result word changed while stalled");

  // An out-of-range result always carries a zero pixel.
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.out_of_range |-> out_word.pixel_out == '0)
    else $error("out-of-range result with nonzero pixel");

  // Reset empties the pipeline, so no result is offered right after it.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind nearest_neighbor_texture_scaler nnts_checker u_nnts_checker (.*);

@@ tb/nearest_neighbor_texture_scaler_tb.sv @@
// Self-checking testbench for the nearest-neighbor texture scaler.
module nearest_neighbor_texture_scaler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nnts_pkg::*;

  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 4;
  // Write words give no result, so after the last read result a few write words
  // may still be in flight.
  localparam int DRAIN_CYCLES   = 24;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_WORDS    = 180;
  localparam int MAX_REPORTS    = 10;
  // First register index that the block does not implement.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = REG_DST_HEIGHT + 1'b1;

  // The scoreboard keeps its own copy of the texture and of the dimension
  // registers. Every accepted write word updates the texture copy, and every
  // read word queues the pixel that the block has to return for it.
  class pixel_scoreboard;
    logic [PIXEL_W-1:0]   texture [STORE_DEPTH_DEF];
    bit                   written [STORE_DEPTH_DEF];
    logic [SRC_DIM_W-1:0] src_width;
    logic [SRC_DIM_W-1:0] src_height;
    logic [DST_DIM_W-1:0] dst_width;
    logic [DST_DIM_W-1:0] dst_height;
    out_word_t            expected_pixels [$];
    int                   mismatches;

    function new();
      src_width  = 1;
      src_height = 1;
      dst_width  = 1;
      dst_height = 1;
      mismatches = 0;
      foreach (written[i]) written[i] = 1'b0;
    endfunction

    // Register writes keep only the bits of the register, so an oversized
    // value wraps just as it does in the block.
    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
      case (idx)
        REG_SRC_WIDTH:  src_width  = value[SRC_DIM_W-1:0];
        REG_SRC_HEIGHT: src_height = value[SRC_DIM_W-1:0];
        REG_DST_WIDTH:  dst_width  = value[DST_DIM_W-1:0];
        REG_DST_HEIGHT: dst_height = value[DST_DIM_W-1:0];
        default: ;
      endcase
    endfunction

    function bit dims_ok();
      return src_width != 0 && src_width <= MAX_SRC_DIM_DEF &&
             src_height != 0 && src_height <= MAX_SRC_DIM_DEF &&
             dst_width != 0 && dst_width <= MAX_DST_DIM_DEF &&
             dst_height != 0 && dst_height <= MAX_DST_DIM_DEF;
    endfunction

    // Store address that a read of (x, y) samples, or -1 when the read is
    // out of range and touches no entry.
    function int read_address(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
      int unsigned col;
      int unsigned row;
      int unsigned addr;
      if (!dims_ok() || x >= dst_width || y >= dst_height) return -1;
      col  = (32'(x) * 32'(src_width)) / 32'(dst_width);
      row  = (32'(y) * 32'(src_height)) / 32'(dst_height);
      addr = row * 32'(src_width) + col;
      if (addr >= STORE_DEPTH_DEF) return -1;
      return int'(addr);
    endfunction

    function void note_word(in_word_t w);
      out_word_t e;
      int        addr;
      if (w.cmd == CMD_WRITE) begin
        texture[w.src_index] = w.pixel_in;
        written[w.src_index] = 1'b1;
        return;
      end
      addr = read_address(w.dst_x, w.dst_y);
      if (addr < 0) begin
        e.pixel_out    = '0;
        e.out_of_range = 1'b1;
      end else begin
        e.pixel_out    = texture[addr];
        e.out_of_range = 1'b0;
      end
      expected_pixels.push_back(e);
    endfunction

    function void check_word(out_word_t got);
      out_word_t e;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result word, pixel %0d out_of_range %0b",
                   $time, got.pixel_out, got.out_of_range);
        return;
      end
      e = expected_pixels.pop_front();
      if (got.pixel_out !== e.pixel_out || got.out_of_range !== e.out_of_range) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: expected pixel %0d out_of_range %0b, got pixel %0d out_of_range %0b",
                   $time, e.pixel_out, e.out_of_range, got.pixel_out, got.out_of_range);
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_word_t             in_word   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_word_t            out_word;

  // Random idling on both sides is switched off for the final phase.
  bit              idle_on = 1'b1;
  int              stall_left = 0;
  int              quiet_cycles = 0;
  pixel_scoreboard board;

  nearest_neighbor_texture_scaler uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always #CLK_HALF clk = ~clk;

  // The receiver stalls in random bursts. The burst length is kept in a
  // blocking counter so that out_stall gets one update per edge.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 7);
    end
    out_stall <= (stall_left != 0);
  end

  // Every result word taken by the receiver is checked against the oldest
  // expected pixel.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) board.check_word(out_word);
  end

  // The watchdog ends a run in which no word moves on either side for too
  // long, which covers a lost result as well as a hung input.
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // The caller lowers cfg_we once after the last register write so that the
  // enable never sees two updates in one time step.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    board.set_reg(idx, value);
  endtask

  task automatic configure(int sw, int sh, int dw, int dh);
    write_reg(REG_SRC_WIDTH,  CFG_DAT_W'(sw));
    write_reg(REG_SRC_HEIGHT, CFG_DAT_W'(sh));
    write_reg(REG_DST_WIDTH,  CFG_DAT_W'(dw));
    write_reg(REG_DST_HEIGHT, CFG_DAT_W'(dh));
    cfg_we <= 1'b0;
  endtask

  // Offers one word, holding it until the block takes it. A random gap may
  // come first. The word is handed to the scoreboard at the accepting edge.
  task automatic put_word(in_word_t w);
    if (idle_on && $urandom_range(0, 11) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    board.note_word(w);
  endtask

  // Fields that a command does not use carry random values all the same.
  task automatic put_write(logic [INDEX_W-1:0] idx, logic [PIXEL_W-1:0] pix);
    in_word_t w;
    w.cmd       = CMD_WRITE;
    w.src_index = idx;
    w.pixel_in  = pix;
    w.dst_x     = COORD_W'($urandom);
    w.dst_y     = COORD_W'($urandom);
    put_word(w);
  endtask

  // A read that would sample an entry never written is preceded by a write
  // of a random pixel to that entry, so the store is only read once filled.
  task automatic put_read(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    in_word_t w;
    int       addr;
    addr = board.read_address(x, y);
    if (addr >= 0 && !board.written[addr]) put_write(INDEX_W'(addr), PIXEL_W'($urandom));
    w.cmd       = CMD_READ;
    w.src_index = INDEX_W'($urandom);
    w.pixel_in  = PIXEL_W'($urandom);
    w.dst_x     = x;
    w.dst_y     = y;
    put_word(w);
  endtask

  // Most reads land inside the output image; the rest use the whole
  // coordinate range and so hit the clipping paths.
  task automatic put_random_read();
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    if (board.dims_ok() && $urandom_range(0, 7) != 0) begin
      x = COORD_W'($urandom_range(0, board.dst_width - 1));
      y = COORD_W'($urandom_range(0, board.dst_height - 1));
    end else begin
      x = COORD_W'($urandom);
      y = COORD_W'($urandom);
    end
    put_read(x, y);
  endtask

  // Stops sending and waits for every expected pixel, then lets trailing
  // write words leave the pipeline before the registers may change.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(int words, bit pause_midway);
    for (int i = 0; i < words; i++) begin
      if (pause_midway && i == words / 2) drain();
      if ($urandom_range(0, 3) == 0) begin
        put_write(INDEX_W'($urandom), PIXEL_W'($urandom));
      end else begin
        put_random_read();
      end
    end
    drain();
  endtask

  // Picks random dimensions; with bad set, one register gets zero or a value
  // above its maximum.
  task automatic random_config(bit bad);
    int dims [4];
    int pick;
    dims[0] = $urandom_range(1, MAX_SRC_DIM_DEF);
    dims[1] = $urandom_range(1, MAX_SRC_DIM_DEF);
    dims[2] = $urandom_range(1, MAX_DST_DIM_DEF);
    dims[3] = $urandom_range(1, MAX_DST_DIM_DEF);
    if (bad) begin
      pick = $urandom_range(0, 3);
      if ($urandom_range(0, 1) == 0) begin
        dims[pick] = 0;
      end else if (pick < 2) begin
        dims[pick] = $urandom_range(MAX_SRC_DIM_DEF + 1, 511);
      end else begin
        dims[pick] = $urandom_range(MAX_DST_DIM_DEF + 1, 2047);
      end
    end
    configure(dims[0], dims[1], dims[2], dims[3]);
  endtask

  initial begin
    board = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset dimensions: a one-pixel image, so only (0, 0) is inside.
    put_write(INDEX_W'(0), 8'hA5);
    put_read(COORD_W'(0), COORD_W'(0));
    put_read(COORD_W'(1), COORD_W'(0));
    put_read(COORD_W'(0), COORD_W'(1));
    put_read(COORD_W'(1023), COORD_W'(1023));
    put_write(INDEX_W'(4095), 8'hFF);
    put_write(INDEX_W'(2730), 8'h00);
    drain();

    // Largest legal sizes: the bottom-right corner maps past the store, the
    // top row and a point in the middle stay inside it.
    configure(MAX_SRC_DIM_DEF, MAX_SRC_DIM_DEF, MAX_DST_DIM_DEF, MAX_DST_DIM_DEF);
    put_read(COORD_W'(1023), COORD_W'(1023));
    put_read(COORD_W'(0), COORD_W'(0));
    put_read(COORD_W'(1023), COORD_W'(0));
    put_read(COORD_W'(60), COORD_W'(60));
    put_read(COORD_W'(4), COORD_W'(64));
    drain();

    // A zero source width makes every read out of range.
    configure(0, MAX_SRC_DIM_DEF, MAX_DST_DIM_DEF, MAX_DST_DIM_DEF);
    put_read(COORD_W'(0), COORD_W'(0));
    drain();

    // All-ones register data: every dimension is above its maximum.
    configure(2047, 2047, 2047, 2047);
    put_read(COORD_W'(5), COORD_W'(5));
    drain();

    // A zero output width.
    configure(1, 1, 0, MAX_DST_DIM_DEF);
    put_read(COORD_W'(0), COORD_W'(0));
    drain();

    // Strongest upscale, followed by writes to indexes the block lacks,
    // which must leave the dimensions alone.
    configure(1, 1, MAX_DST_DIM_DEF, MAX_DST_DIM_DEF);
    write_reg(REG_UNUSED, CFG_DAT_W'($urandom));
    write_reg(REG_UNUSED + CFG_IDX_W'($urandom_range(1, 3)), '0);
    cfg_we <= 1'b0;
    put_read(COORD_W'(1023), COORD_W'(1023));
    put_read(COORD_W'(512), COORD_W'(0));
    drain();

    // Random phases over fixed corner settings and random ones. The first
    // phase also pauses the sender midway until all results are back.
    configure(MAX_SRC_DIM_DEF, MAX_SRC_DIM_DEF, MAX_DST_DIM_DEF, MAX_DST_DIM_DEF);
    run_phase(PHASE_WORDS, 1'b1);
    configure(64, 64, MAX_DST_DIM_DEF, MAX_DST_DIM_DEF);
    run_phase(PHASE_WORDS, 1'b0);
    configure(MAX_SRC_DIM_DEF, 16, 256, 16);
    run_phase(PHASE_WORDS, 1'b0);
    configure(1, 1, MAX_DST_DIM_DEF, MAX_DST_DIM_DEF);
    run_phase(PHASE_WORDS, 1'b0);
    configure(200, 20, 7, 3);
    run_phase(PHASE_WORDS, 1'b0);
    random_config(1'b0);
    run_phase(PHASE_WORDS, 1'b0);
    random_config(1'b1);
    run_phase(PHASE_WORDS, 1'b0);
    random_config(1'b0);
    run_phase(PHASE_WORDS, 1'b0);

    // Final phase at full rate with no idling on either side.
    idle_on = 1'b0;
    random_config(1'b0);
    run_phase(PHASE_WORDS, 1'b0);

    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
